@@ design/lrs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lrs_pkg;

  // Sizes of the sorter.
  localparam int MAX_ITEMS = 64;
  localparam int KEY_BYTES = 8;
  localparam int RADIX     = 256;

  localparam int KEY_W  = 64;
  localparam int BKT_W  = 8;
  localparam int POS_W  = 3;
  localparam int PASS_W = POS_W + 1;
  localparam int IDX_W  = $clog2(MAX_ITEMS);
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int PFX_W  = $clog2(RADIX + 1);

  // The first byte examined, and the buffer that holds the result after all passes.
  localparam int FIRST_POS  = 8 - KEY_BYTES;
  localparam bit FINAL_IN_B = (KEY_BYTES % 2) == 1;

  // Command to one key buffer.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [KEY_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } buf_cmd_t;

  // Command to the bucket count store.
  typedef struct packed {
    logic             clr;
    logic             we;
    logic [BKT_W-1:0] waddr;
    logic [CNT_W-1:0] wdata;
    logic             re;
    logic [BKT_W-1:0] raddr;
  } bkt_cmd_t;

endpackage

`default_nettype wire

@@ design/lrs_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lrs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // One registered read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/lrs_bucket.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lrs_bucket (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lrs_pkg::bkt_cmd_t cmd_i,
  output logic [lrs_pkg::CNT_W-1:0] rdata_o
);
  import lrs_pkg::*;

  logic [RADIX-1:0] vld_q;
  logic             rvld_q;
  logic [CNT_W-1:0] ram_rdata;

  lrs_ram #(
    .WIDTH (CNT_W),
    .DEPTH (RADIX)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.we),
    .waddr_i (cmd_i.waddr),
    .wdata_i (cmd_i.wdata),
    .re_i    (cmd_i.re),
    .raddr_i (cmd_i.raddr),
    .rdata_o (ram_rdata)
  );

  // Valid bits: a clear empties every bucket at once, a write marks its bucket.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        vld_q <= '0;
      end else if (cmd_i.we) begin
        vld_q[cmd_i.waddr] <= 1'b1;
      end
      if (cmd_i.re) begin
        rvld_q <= vld_q[cmd_i.raddr];
      end
    end
  end

  // A bucket that was not written in this pass reads as zero.
  assign rdata_o = rvld_q ? ram_rdata : '0;

endmodule

`default_nettype wire

@@ design/lrs_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lrs_seq (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [lrs_pkg::KEY_W-1:0] key_value_i,
  input  wire logic                      last_key_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic                           last_out_o,
  output logic                           overflow_o,
  output lrs_pkg::buf_cmd_t              buf_a_cmd_o,
  output lrs_pkg::buf_cmd_t              buf_b_cmd_o,
  input  wire logic [lrs_pkg::KEY_W-1:0] buf_a_rdata_i,
  input  wire logic [lrs_pkg::KEY_W-1:0] buf_b_rdata_i,
  output lrs_pkg::bkt_cmd_t              bkt_cmd_o,
  input  wire logic [lrs_pkg::CNT_W-1:0] bkt_rdata_i
);
  import lrs_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD,
    S_CNT_RD,
    S_CNT_LK,
    S_CNT_WR,
    S_PFX,
    S_PLC_RD,
    S_PLC_LK,
    S_PLC_WR,
    S_OUT_RD,
    S_OUT_VLD
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              ovf_q, ovf_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [PASS_W-1:0] pass_q, pass_d;
  logic [PFX_W-1:0]  pfx_q, pfx_d;
  logic [CNT_W-1:0]  base_q, base_d;
  logic [BKT_W-1:0]  bkt_q, bkt_d;

  logic              src_is_b;
  logic [KEY_W-1:0]  src_rdata;
  logic [POS_W-1:0]  pos;
  logic [BKT_W-1:0]  cur_byte;
  logic              idx_last;
  logic              pass_last;
  logic [CNT_W-1:0]  add_a, add_b, add_sum;
  buf_cmd_t          src_cmd, dst_cmd, load_cmd, out_cmd;

  // Pass parity picks the source buffer; the loaded keys start in buffer A.
  assign src_is_b  = pass_q[0];
  assign src_rdata = src_is_b ? buf_b_rdata_i : buf_a_rdata_i;
  assign pos       = POS_W'(FIRST_POS) + pass_q[POS_W-1:0];
  assign cur_byte  = src_rdata[{pos, 3'b000} +: BKT_W];
  assign idx_last  = (idx_q == cnt_q - CNT_W'(1));
  assign pass_last = (pass_q == PASS_W'(KEY_BYTES - 1));

  // Shared adder: count increment, slot advance and prefix accumulation.
  assign add_sum = add_a + add_b;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    idx_d   = idx_q;
    pass_d  = pass_q;
    pfx_d   = pfx_q;
    base_d  = base_q;
    bkt_d   = bkt_q;
    add_a   = bkt_rdata_i;
    add_b   = CNT_W'(1);
    src_cmd  = '0;
    dst_cmd  = '0;
    load_cmd = '0;
    out_cmd  = '0;
    bkt_cmd_o = '0;

    case (state_q)
      // Keys are stored in arrival order; a word that finds the buffer full is dropped.
      S_LOAD: begin
        if (in_valid_i) begin
          if (cnt_q < CNT_W'(MAX_ITEMS)) begin
            load_cmd.we    = 1'b1;
            load_cmd.waddr = cnt_q[IDX_W-1:0];
            load_cmd.wdata = key_value_i;
            cnt_d          = cnt_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (last_key_i) begin
            idx_d         = '0;
            pass_d        = '0;
            bkt_cmd_o.clr = 1'b1;
            state_d       = S_CNT_RD;
          end
        end
      end
      // Counting: read a key, read its bucket, write the bucket back plus one.
      S_CNT_RD: begin
        src_cmd.re    = 1'b1;
        src_cmd.raddr = idx_q[IDX_W-1:0];
        state_d       = S_CNT_LK;
      end
      S_CNT_LK: begin
        bkt_cmd_o.re    = 1'b1;
        bkt_cmd_o.raddr = cur_byte;
        bkt_d           = cur_byte;
        state_d         = S_CNT_WR;
      end
      S_CNT_WR: begin
        bkt_cmd_o.we    = 1'b1;
        bkt_cmd_o.waddr = bkt_q;
        bkt_cmd_o.wdata = add_sum;
        if (idx_last) begin
          idx_d   = '0;
          pfx_d   = '0;
          base_d  = '0;
          state_d = S_PFX;
        end else begin
          idx_d   = idx_q + CNT_W'(1);
          state_d = S_CNT_RD;
        end
      end
      // Exclusive prefix sum: read bucket j while bucket j-1 takes the running base.
      S_PFX: begin
        add_a = base_q;
        add_b = bkt_rdata_i;
        if (pfx_q != PFX_W'(RADIX)) begin
          bkt_cmd_o.re    = 1'b1;
          bkt_cmd_o.raddr = pfx_q[BKT_W-1:0];
        end
        if (pfx_q != '0) begin
          bkt_cmd_o.we    = 1'b1;
          bkt_cmd_o.waddr = BKT_W'(pfx_q - PFX_W'(1));
          bkt_cmd_o.wdata = base_q;
          base_d          = add_sum;
        end
        if (pfx_q == PFX_W'(RADIX)) begin
          idx_d   = '0;
          state_d = S_PLC_RD;
        end else begin
          pfx_d = pfx_q + PFX_W'(1);
        end
      end
      // Placement: the bucket holds the next free slot of its byte value.
      S_PLC_RD: begin
        src_cmd.re    = 1'b1;
        src_cmd.raddr = idx_q[IDX_W-1:0];
        state_d       = S_PLC_LK;
      end
      S_PLC_LK: begin
        bkt_cmd_o.re    = 1'b1;
        bkt_cmd_o.raddr = cur_byte;
        bkt_d           = cur_byte;
        state_d         = S_PLC_WR;
      end
      S_PLC_WR: begin
        dst_cmd.we      = 1'b1;
        dst_cmd.waddr   = bkt_rdata_i[IDX_W-1:0];
        dst_cmd.wdata   = src_rdata;
        bkt_cmd_o.we    = 1'b1;
        bkt_cmd_o.waddr = bkt_q;
        bkt_cmd_o.wdata = add_sum;
        idx_d           = '0;
        if (!idx_last) begin
          idx_d   = idx_q + CNT_W'(1);
          state_d = S_PLC_RD;
        end else if (pass_last) begin
          state_d = S_OUT_RD;
        end else begin
          pass_d        = pass_q + PASS_W'(1);
          bkt_cmd_o.clr = 1'b1;
          state_d       = S_CNT_RD;
        end
      end
      // Results: fetch one sorted key, then hold it until the word is taken.
      S_OUT_RD: begin
        out_cmd.re    = 1'b1;
        out_cmd.raddr = idx_q[IDX_W-1:0];
        state_d       = S_OUT_VLD;
      end
      S_OUT_VLD: begin
        if (out_ready_i) begin
          if (idx_last) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            idx_d   = '0;
            state_d = S_LOAD;
          end else begin
            idx_d   = idx_q + CNT_W'(1);
            state_d = S_OUT_RD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // Route source, destination, load and result accesses to the two buffers.
  always_comb begin
    buf_a_cmd_o = '0;
    buf_b_cmd_o = '0;
    if (state_q == S_LOAD) begin
      buf_a_cmd_o = load_cmd;
    end else if (state_q == S_OUT_RD || state_q == S_OUT_VLD) begin
      if (FINAL_IN_B) begin
        buf_b_cmd_o = out_cmd;
      end else begin
        buf_a_cmd_o = out_cmd;
      end
    end else if (src_is_b) begin
      buf_b_cmd_o.re    = src_cmd.re;
      buf_b_cmd_o.raddr = src_cmd.raddr;
      buf_a_cmd_o.we    = dst_cmd.we;
      buf_a_cmd_o.waddr = dst_cmd.waddr;
      buf_a_cmd_o.wdata = dst_cmd.wdata;
    end else begin
      buf_a_cmd_o.re    = src_cmd.re;
      buf_a_cmd_o.raddr = src_cmd.raddr;
      buf_b_cmd_o.we    = dst_cmd.we;
      buf_b_cmd_o.waddr = dst_cmd.waddr;
      buf_b_cmd_o.wdata = dst_cmd.wdata;
    end
  end

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      idx_q   <= '0;
      pass_q  <= '0;
      pfx_q   <= '0;
      base_q  <= '0;
      bkt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      idx_q   <= idx_d;
      pass_q  <= pass_d;
      pfx_q   <= pfx_d;
      base_q  <= base_d;
      bkt_q   <= bkt_d;
    end
  end

  assign in_ready_o  = (state_q == S_LOAD);
  assign out_valid_o = (state_q == S_OUT_VLD);
  assign last_out_o  = idx_last;
  assign overflow_o  = ovf_q;

  // Input and output sides are never open at the same time.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_ready_o |-> !out_valid_o)
    else $error("input ready while a result is shown");

  // The key count never passes the buffer depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CNT_W'(MAX_ITEMS))
    else $error("key count beyond capacity");

  // Every placement slot falls inside the loaded set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PLC_WR) |-> (bkt_rdata_i < cnt_q))
    else $error("placement slot outside the set");

  // Taking the final result word reopens the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_out_o) |=> (in_ready_o && cnt_q == '0 && !ovf_q))
    else $error("block not emptied after the final result");

endmodule

`default_nettype wire

@@ design/lsd_radix_sort_u64.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake                 Word
// input    in         in_valid_i / in_ready_o   key_value_i, last_key_i
// output   out        out_valid_o / out_ready_i sorted_value_o, last_out_o, overflow_o
//
// Loading accepts one key per cycle. The word flagged last starts the sort, which runs
// eight byte passes: each pass steps the shared adder through the key buffer and the
// bucket memory per key for counting, then through a prefix sum over the buckets, then
// per key again for placement. Each result is read, then held until it is taken.
// Reset clears only control state and the bucket valid bits; no clearing pass is run.
// The input is not ready while a set is sorted or emitted; a stalled result word holds.
module lsd_radix_sort_u64 (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [lrs_pkg::KEY_W-1:0] key_value_i,
  input  wire logic                      last_key_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic      [lrs_pkg::KEY_W-1:0] sorted_value_o,
  output logic                           last_out_o,
  output logic                           overflow_o
);
  import lrs_pkg::*;

  buf_cmd_t         buf_a_cmd, buf_b_cmd;
  bkt_cmd_t         bkt_cmd;
  logic [KEY_W-1:0] buf_a_rdata, buf_b_rdata;
  logic [CNT_W-1:0] bkt_rdata;

  // Sequencer with the shared adder.
  lrs_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .key_value_i   (key_value_i),
    .last_key_i    (last_key_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .last_out_o    (last_out_o),
    .overflow_o    (overflow_o),
    .buf_a_cmd_o   (buf_a_cmd),
    .buf_b_cmd_o   (buf_b_cmd),
    .buf_a_rdata_i (buf_a_rdata),
    .buf_b_rdata_i (buf_b_rdata),
    .bkt_cmd_o     (bkt_cmd),
    .bkt_rdata_i   (bkt_rdata)
  );

  // Ping-pong key buffers.
  lrs_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_ITEMS)
  ) u_buf_a (
    .clk_i   (clk_i),
    .we_i    (buf_a_cmd.we),
    .waddr_i (buf_a_cmd.waddr),
    .wdata_i (buf_a_cmd.wdata),
    .re_i    (buf_a_cmd.re),
    .raddr_i (buf_a_cmd.raddr),
    .rdata_o (buf_a_rdata)
  );

  lrs_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_ITEMS)
  ) u_buf_b (
    .clk_i   (clk_i),
    .we_i    (buf_b_cmd.we),
    .waddr_i (buf_b_cmd.waddr),
    .wdata_i (buf_b_cmd.wdata),
    .re_i    (buf_b_cmd.re),
    .raddr_i (buf_b_cmd.raddr),
    .rdata_o (buf_b_rdata)
  );

  // Bucket counts with per-bucket valid bits.
  lrs_bucket u_bucket (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (bkt_cmd),
    .rdata_o (bkt_rdata)
  );

  // The sorted set ends in the buffer that the last pass wrote.
  assign sorted_value_o = FINAL_IN_B ? buf_b_rdata : buf_a_rdata;

endmodule

`default_nettype wire

@@ verif/lsd_radix_sort_u64_test.sv @@
`timescale 1ns / 1ps

module lsd_radix_sort_u64_test;

  localparam int STALL_LIMIT = 50000;
  localparam int HOLD_CYCLES = 6000;
  localparam int DRAIN_CYCLES = 64;
  localparam int PHASE_ITEMS = 130;
  localparam int SKIP_BITS = lrs_pkg::FIRST_POS * 8;
  localparam int N_DIR = 23;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [63:0] value;
    logic        last;
    logic        ovf;
  } sorted_word_t;

  typedef struct {
    logic [63:0] key;
    logic        last;
    bit          typed;
    logic [63:0] exp_value;
    logic        exp_ovf;
  } stim_row_t;

  typedef enum int {KEY_RANDOM, KEY_EDGE_BYTES, KEY_NEAR_PREV} key_style_e;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [63:0] key_value_i;
  logic        last_key_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [63:0] sorted_value_o;
  logic        last_out_o;
  logic        overflow_o;

  // Keys held for the current set and the sorted words still to come.
  logic [63:0]  held_keys[$];
  logic         held_ovf;
  sorted_word_t sorted_expect[$];

  int  tx_idle_pct;
  int  rx_idle_pct;
  bit  hold_req;
  int  mismatches;
  int  stall_cycles;
  int  phase_items;
  stim_row_t dir_rows [N_DIR];

  lsd_radix_sort_u64 dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .key_value_i   (key_value_i),
    .last_key_i    (last_key_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sorted_value_o(sorted_value_o),
    .last_out_o    (last_out_o),
    .overflow_o    (overflow_o)
  );

  // Clock with a 12 ns period.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Store a key, and on the last word of a set produce the sorted words.
  // A stable insertion sort on the examined bytes matches the byte passes.
  function automatic void predict_word(input logic [63:0] key, input logic last);
    logic [63:0]  keys[$];
    logic [63:0]  tmp;
    int           j;
    sorted_word_t w;
    if (held_keys.size() < lrs_pkg::MAX_ITEMS) held_keys.push_back(key);
    else held_ovf = 1'b1;
    if (last) begin
      keys = held_keys;
      for (int i = 1; i < keys.size(); i++) begin
        j = i;
        while (j > 0 && (keys[j-1] >> SKIP_BITS) > (keys[j] >> SKIP_BITS)) begin
          tmp = keys[j-1];
          keys[j-1] = keys[j];
          keys[j] = tmp;
          j--;
        end
      end
      for (int i = 0; i < keys.size(); i++) begin
        w.value = keys[i];
        w.last = (i == keys.size() - 1);
        w.ovf = held_ovf;
        sorted_expect.push_back(w);
      end
      held_keys.delete();
      held_ovf = 1'b0;
    end
  endfunction

  // Random keys: fully random, built from edge byte values, or a neighbor of the
  // previous key so that many keys share buckets.
  function automatic logic [63:0] rand_key(input logic [63:0] prev);
    key_style_e  style;
    logic [63:0] k;
    logic [7:0]  edge_bytes [6];
    int          pos;
    edge_bytes = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF};
    style = key_style_e'($urandom_range(2));
    case (style)
      KEY_EDGE_BYTES: begin
        for (int b = 0; b < 8; b++) k[b*8 +: 8] = edge_bytes[$urandom_range(5)];
      end
      KEY_NEAR_PREV: begin
        k = prev;
        pos = $urandom_range(7);
        k[pos*8 +: 8] = 8'($urandom());
      end
      default: k = {$urandom(), $urandom()};
    endcase
    return k;
  endfunction

  // Mostly small sets; some large, some exactly full, a few beyond capacity.
  function automatic int pick_set_size();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(8, 1);
    if (r < 90) return $urandom_range(40, 9);
    if (r < 97) return lrs_pkg::MAX_ITEMS;
    return $urandom_range(lrs_pkg::MAX_ITEMS + 4, lrs_pkg::MAX_ITEMS + 1);
  endfunction

  // Offer one word and return at the edge where it is accepted.
  task automatic push_word(input logic [63:0] key, input logic last);
    in_valid_i <= 1'b1;
    key_value_i <= key;
    last_key_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Random gaps between words on the sending side.
  task automatic sender_gap();
    if (int'($urandom_range(99)) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while (int'($urandom_range(99)) < tx_idle_pct) @(posedge clk_i);
    end
  endtask

  task automatic send_set(input int size);
    logic [63:0] key;
    key = {$urandom(), $urandom()};
    for (int i = 0; i < size; i++) begin
      key = rand_key(key);
      push_word(key, i == size - 1);
      predict_word(key, i == size - 1);
      phase_items++;
      sender_gap();
    end
  endtask

  task automatic run_phase(input int first_size);
    phase_items = 0;
    send_set(first_size);
    while (phase_items < PHASE_ITEMS) send_set(pick_set_size());
  endtask

  // Receiver: random ready, or a long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready_i <= (int'($urandom_range(99)) >= rx_idle_pct);
      end
    end
  end

  // Compare each accepted sorted word with the oldest expectation.
  always @(posedge clk_i) begin
    sorted_word_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sorted_expect.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected word value=%h last=%b ovf=%b", $realtime,
                   sorted_value_o, last_out_o, overflow_o);
        mismatches++;
      end else begin
        w = sorted_expect.pop_front();
        if (sorted_value_o !== w.value || last_out_o !== w.last || overflow_o !== w.ovf) begin
          if (mismatches < 10)
            $display("%0t: mismatch exp value=%h last=%b ovf=%b got value=%h last=%b ovf=%b",
                     $realtime, w.value, w.last, w.ovf, sorted_value_o, last_out_o,
                     overflow_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
        $display("** lsd_radix_sort_u64: FAILED **");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    key_value_i = '0;
    last_key_i = 1'b0;
    out_ready_i = 1'b0;
    held_ovf = 1'b0;
    hold_req = 1'b0;
    mismatches = 0;
    stall_cycles = 0;
    tx_idle_pct = 25;
    rx_idle_pct = 71;

    // Directed words: single-key sets at the extremes, then sets that differ in
    // one byte position, duplicates, and keys given in descending order.
    dir_rows = '{
      '{64'h0, 1'b1, 1'b1, 64'h0, 1'b0},
      '{ALL_ONES, 1'b1, 1'b1, ALL_ONES, 1'b0},
      '{64'h0123_4567_89AB_CDEF, 1'b1, 1'b1, 64'h0123_4567_89AB_CDEF, 1'b0},
      '{64'h0000_0000_0000_0100, 1'b0, 1'b0, 64'h0, 1'b0},
      '{64'h0000_0000_0000_00FF, 1'b0, 1'b0, 64'h0, 1'b0},
      '{64'h8000_0000_0000_0000, 1'b0, 1'b0, 64'h0, 1'b0},
      '{64'h0000_0000_0000_0001, 1'b0, 1'b0, 64'h0, 1'b0},
      '{64'h0000_0000_0000_00FF, 1'b0, 1'b0, 64'h0, 1'b0},
      '{ALL_ONES, 1'b0, 1'b0, 64'h0, 1'b0},
      '{64'h0, 1'b1, 1'b0, 64'h0, 1'b0},
      '{64'hFF00_0000_0000_0000, 1'b0, 1'b0, 64'h0, 1'b0},
      '{64'h0100_0000_0000_00FF, 1'b0, 1'b0, 64'h0, 1'b0},
      '{64'h00FF_0000_0000_0000, 1'b0, 1'b0, 64'h0, 1'b0},
      '{64'h0000_0000_0001_0000, 1'b0, 1'b0, 64'h0, 1'b0},
      '{64'h0000_0000_0000_FFFF, 1'b1, 1'b0, 64'h0, 1'b0},
      '{64'h0100_0000_0000_0000, 1'b0, 1'b0, 64'h0, 1'b0},
      '{64'h0001_0000_0000_0000, 1'b0, 1'b0, 64'h0, 1'b0},
      '{64'h0000_0100_0000_0000, 1'b0, 1'b0, 64'h0, 1'b0},
      '{64'h0000_0001_0000_0000, 1'b0, 1'b0, 64'h0, 1'b0},
      '{64'h0000_0000_0100_0000, 1'b0, 1'b0, 64'h0, 1'b0},
      '{64'h0000_0000_0001_0000, 1'b0, 1'b0, 64'h0, 1'b0},
      '{64'h0000_0000_0000_0100, 1'b0, 1'b0, 64'h0, 1'b0},
      '{64'h0000_0000_0000_0001, 1'b1, 1'b0, 64'h0, 1'b0}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sender idles often, receiver idles more.
    for (int r = 0; r < N_DIR; r++) begin
      push_word(dir_rows[r].key, dir_rows[r].last);
      if (dir_rows[r].typed)
        sorted_expect.push_back('{dir_rows[r].exp_value, 1'b1, dir_rows[r].exp_ovf});
      else
        predict_word(dir_rows[r].key, dir_rows[r].last);
      sender_gap();
    end
    run_phase(lrs_pkg::MAX_ITEMS);

    // Pause the sender until every sorted word of the phase has arrived.
    in_valid_i <= 1'b0;
    while (sorted_expect.size() != 0) @(posedge clk_i);

    // Roles swapped; the first set drops two keys, the last one among them.
    tx_idle_pct = 71;
    rx_idle_pct = 25;
    run_phase(lrs_pkg::MAX_ITEMS + 2);

    // No idling, and a long receiver hold-off while words keep coming.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req = 1'b1;
    run_phase(pick_set_size());

    in_valid_i <= 1'b0;
    while (sorted_expect.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && sorted_expect.size() == 0) begin
      $display("** lsd_radix_sort_u64: PASSED **");
    end else begin
      $display("** lsd_radix_sort_u64: FAILED **");
    end
    $finish;
  end

endmodule
